### rtl/wire_frame_receiver_crc32_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wire frame receiver
// Shared concurrent assertion forms, clocked and disabled by an active low reset.
// ----------------------------------------------------------------------------
`ifndef WIRE_FRAME_RECEIVER_CRC32_TOP_ASSERT_SVH
`define WIRE_FRAME_RECEIVER_CRC32_TOP_ASSERT_SVH

// same-cycle implication
`define WFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wfr assertion failed");

// next-cycle implication
`define WFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wfr assertion failed");

`endif

### rtl/wfr_pkg.sv
// ----------------------------------------------------------------------------
// wfr_pkg
// Constants, verdict codes, result type and CRC-32 byte update for the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wfr_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 192;
  localparam int unsigned HDR_BYTES       = 16;
  localparam int unsigned CFG_IDX_W       = 1;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [7:0] VERSION_OK = 8'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_OP  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SEQ = 1'd1;

  localparam logic [2:0] VERDICT_OK       = 3'd0;
  localparam logic [2:0] VERDICT_MAGIC    = 3'd1;
  localparam logic [2:0] VERDICT_VERSION  = 3'd2;
  localparam logic [2:0] VERDICT_OP       = 3'd3;
  localparam logic [2:0] VERDICT_SEQUENCE = 3'd4;
  localparam logic [2:0] VERDICT_OVERSIZE = 3'd5;
  localparam logic [2:0] VERDICT_CRC      = 3'd6;

  localparam logic ITEM_PAYLOAD = 1'b0;
  localparam logic ITEM_STATUS  = 1'b1;

  typedef struct packed {
    logic        valid;
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  byte_index;
    logic [15:0] frame_flags;
    logic [15:0] fragment_offset;
    logic [7:0]  payload_size;
    logic [2:0]  verdict;
    logic        frame_last;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'h4A;
      2'd1:    m = 8'h32;
      2'd2:    m = 8'h35;
      default: m = 8'h33;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic logic [7:0] sat8(input logic [15:0] v);
    return (|v[15:8]) ? 8'hFF : v[7:0];
  endfunction

endpackage

### rtl/wfr_parser.sv
// ----------------------------------------------------------------------------
// wfr_parser
// Frame parser: header checks, payload byte items, CRC-32 and status item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "wire_frame_receiver_crc32_top_assert.svh"

module wfr_parser #(
  parameter int unsigned MAX_PAYLOAD = wfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [7:0]        expected_op_i,
  input  logic [31:0]       expected_seq_i,
  output wfr_pkg::result_t  result_o
);

  localparam int unsigned PW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [15:0] MAX_SIZE = 16'(MAX_PAYLOAD);

  localparam logic [1:0] ST_HDR = 2'd0;
  localparam logic [1:0] ST_PAY = 2'd1;
  localparam logic [1:0] ST_CRC = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [3:0]    hdr_pos_q, hdr_pos_d;
  logic [PW-1:0] pay_idx_q, pay_idx_d;
  logic [1:0]    crc_pos_q, crc_pos_d;
  logic [31:0]   crc_q, crc_d;
  logic [15:0]   flags_q, flags_d;
  logic [15:0]   offset_q, offset_d;
  logic [15:0]   size_q, size_d;
  logic [2:0]    fault_q, fault_d;
  logic [31:0]   seq_q, seq_d;
  logic [31:0]   rcv_q, rcv_d;

  logic [2:0]    chk;
  logic [PW-1:0] pay_idx_nx;
  logic [31:0]   rcv_full;
  wfr_pkg::result_t res;

  always_comb begin
    state_d    = state_q;
    hdr_pos_d  = hdr_pos_q;
    pay_idx_d  = pay_idx_q;
    crc_pos_d  = crc_pos_q;
    crc_d      = crc_q;
    flags_d    = flags_q;
    offset_d   = offset_q;
    size_d     = size_q;
    fault_d    = fault_q;
    seq_d      = seq_q;
    rcv_d      = rcv_q;
    chk        = wfr_pkg::VERDICT_OK;
    pay_idx_nx = pay_idx_q + PW'(1);
    rcv_full   = {rx_byte_i, rcv_q[23:0]};
    res        = '0;

    if (step_i) begin
      case (state_q)
        ST_HDR: begin
          if (hdr_pos_q >= 4'd4) begin
            crc_d = wfr_pkg::crc_byte(crc_q, rx_byte_i);
          end
          case (hdr_pos_q)
            4'd0, 4'd1, 4'd2, 4'd3: begin
              if (rx_byte_i != wfr_pkg::magic_byte(hdr_pos_q[1:0])) begin
                chk = wfr_pkg::VERDICT_MAGIC;
              end
            end
            4'd4: begin
              if (rx_byte_i != wfr_pkg::VERSION_OK) begin
                chk = wfr_pkg::VERDICT_VERSION;
              end
            end
            4'd5: begin
              if (rx_byte_i != expected_op_i) begin
                chk = wfr_pkg::VERDICT_OP;
              end
            end
            4'd6:  flags_d[7:0]   = rx_byte_i;
            4'd7:  flags_d[15:8]  = rx_byte_i;
            4'd8:  seq_d[7:0]     = rx_byte_i;
            4'd9:  seq_d[15:8]    = rx_byte_i;
            4'd10: seq_d[23:16]   = rx_byte_i;
            4'd11: begin
              seq_d[31:24] = rx_byte_i;
              if ({rx_byte_i, seq_q[23:0]} != expected_seq_i) begin
                chk = wfr_pkg::VERDICT_SEQUENCE;
              end
            end
            4'd12: offset_d[7:0]  = rx_byte_i;
            4'd13: offset_d[15:8] = rx_byte_i;
            4'd14: size_d[7:0]    = rx_byte_i;
            default: begin
              size_d[15:8] = rx_byte_i;
              if ({rx_byte_i, size_q[7:0]} > MAX_SIZE) begin
                chk = wfr_pkg::VERDICT_OVERSIZE;
              end
            end
          endcase
          if (fault_q == wfr_pkg::VERDICT_OK) begin
            fault_d = chk;
          end
          if (hdr_pos_q == 4'd15) begin
            hdr_pos_d = '0;
            pay_idx_d = '0;
            crc_pos_d = '0;
            if (fault_d != wfr_pkg::VERDICT_OK) begin
              res.valid           = 1'b1;
              res.item_kind       = wfr_pkg::ITEM_STATUS;
              res.frame_flags     = flags_q;
              res.fragment_offset = offset_q;
              res.payload_size    = wfr_pkg::sat8(size_d);
              res.verdict         = fault_d;
              res.frame_last      = 1'b1;
              crc_d   = wfr_pkg::CRC_INIT;
              fault_d = wfr_pkg::VERDICT_OK;
              rcv_d   = '0;
            end else if (size_d == 16'd0) begin
              state_d = ST_CRC;
            end else begin
              state_d = ST_PAY;
            end
          end else begin
            hdr_pos_d = hdr_pos_q + 4'd1;
          end
        end
        ST_PAY: begin
          crc_d            = wfr_pkg::crc_byte(crc_q, rx_byte_i);
          res.valid        = 1'b1;
          res.item_kind    = wfr_pkg::ITEM_PAYLOAD;
          res.payload_byte = rx_byte_i;
          res.byte_index   = wfr_pkg::sat8(16'(pay_idx_q));
          pay_idx_d        = pay_idx_nx;
          if (pay_idx_nx == size_q[PW-1:0]) begin
            state_d   = ST_CRC;
            crc_pos_d = '0;
          end
        end
        ST_CRC: begin
          case (crc_pos_q)
            2'd0:    rcv_d[7:0]   = rx_byte_i;
            2'd1:    rcv_d[15:8]  = rx_byte_i;
            2'd2:    rcv_d[23:16] = rx_byte_i;
            default: rcv_d[31:24] = rx_byte_i;
          endcase
          crc_pos_d = crc_pos_q + 2'd1;
          if (crc_pos_q == 2'd3) begin
            res.valid           = 1'b1;
            res.item_kind       = wfr_pkg::ITEM_STATUS;
            res.frame_flags     = flags_q;
            res.fragment_offset = offset_q;
            res.payload_size    = wfr_pkg::sat8(size_q);
            res.verdict         = (rcv_full == ~crc_q) ? wfr_pkg::VERDICT_OK
                                                       : wfr_pkg::VERDICT_CRC;
            res.frame_last      = 1'b1;
            state_d   = ST_HDR;
            hdr_pos_d = '0;
            crc_d     = wfr_pkg::CRC_INIT;
            fault_d   = wfr_pkg::VERDICT_OK;
            rcv_d     = '0;
          end
        end
        default: begin
          state_d   = ST_HDR;
          hdr_pos_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_HDR;
      hdr_pos_q <= '0;
      pay_idx_q <= '0;
      crc_pos_q <= '0;
      crc_q     <= wfr_pkg::CRC_INIT;
      flags_q   <= '0;
      offset_q  <= '0;
      size_q    <= '0;
      fault_q   <= wfr_pkg::VERDICT_OK;
      seq_q     <= '0;
      rcv_q     <= '0;
    end else begin
      state_q   <= state_d;
      hdr_pos_q <= hdr_pos_d;
      pay_idx_q <= pay_idx_d;
      crc_pos_q <= crc_pos_d;
      crc_q     <= crc_d;
      flags_q   <= flags_d;
      offset_q  <= offset_d;
      size_q    <= size_d;
      fault_q   <= fault_d;
      seq_q     <= seq_d;
      rcv_q     <= rcv_d;
    end
  end

  assign result_o = res;

  `WFR_ASSERT_NEXT(a_status_restarts, clk_i, rst_ni,
                   res.valid && res.item_kind == wfr_pkg::ITEM_STATUS,
                   state_q == ST_HDR && hdr_pos_q == 4'd0 && crc_q == wfr_pkg::CRC_INIT)
  `WFR_ASSERT_NOW(a_payload_in_range, clk_i, rst_ni,
                  state_q == ST_PAY,
                  size_q <= MAX_SIZE && size_q != 16'd0 && 16'(pay_idx_q) < size_q)
  `WFR_ASSERT_NOW(a_no_fault_after_hdr, clk_i, rst_ni,
                  state_q != ST_HDR,
                  fault_q == wfr_pkg::VERDICT_OK)

endmodule

### rtl/wire_frame_receiver_crc32_top.sv
// ----------------------------------------------------------------------------
// wire_frame_receiver_crc32_top
// Framed byte stream receiver with header checks and CRC-32 verification.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   rx_byte_i
//   out      source     out_valid_o / out_stall_i item_kind_o .. frame_last_o
//   cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One byte per cycle unless the output stalls; a byte sits in the input register
// after the edge that accepts it, and any result is loaded into the output register
// as the parser steps; the per-byte CRC update and header checks sit between them.
// Reset clears all parser state; no clearing pass is needed.
// A stalled output holds the result register and backs up into the input
// register; the input stalls only when both are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wire_frame_receiver_crc32_top #(
  parameter int unsigned MAX_PAYLOAD = wfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          item_kind_o,
  output logic [7:0]                    payload_byte_o,
  output logic [7:0]                    byte_index_o,
  output logic [15:0]                   frame_flags_o,
  output logic [15:0]                   fragment_offset_o,
  output logic [7:0]                    payload_size_o,
  output logic [2:0]                    verdict_o,
  output logic                          frame_last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wfr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic [7:0]       exp_op_q;
  logic [31:0]      exp_seq_q;
  logic             adv;
  logic             step;
  wfr_pkg::result_t res;
  wfr_pkg::result_t out_q;

  assign adv        = !out_q.valid || !out_stall_i;
  assign step       = in_valid_q && adv;
  assign in_stall_o = in_valid_q && !adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_op_q  <= '0;
      exp_seq_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        wfr_pkg::CFG_EXPECTED_OP:  exp_op_q  <= cfg_data_i[7:0];
        wfr_pkg::CFG_EXPECTED_SEQ: exp_seq_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  wfr_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .rx_byte_i      (in_byte_q),
    .expected_op_i  (exp_op_q),
    .expected_seq_i (exp_seq_q),
    .result_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (adv) begin
      out_q.valid <= res.valid;
      if (res.valid) begin
        out_q.item_kind       <= res.item_kind;
        out_q.payload_byte    <= res.payload_byte;
        out_q.byte_index      <= res.byte_index;
        out_q.frame_flags     <= res.frame_flags;
        out_q.fragment_offset <= res.fragment_offset;
        out_q.payload_size    <= res.payload_size;
        out_q.verdict         <= res.verdict;
        out_q.frame_last      <= res.frame_last;
      end
    end
  end

  assign out_valid_o       = out_q.valid;
  assign item_kind_o       = out_q.item_kind;
  assign payload_byte_o    = out_q.payload_byte;
  assign byte_index_o      = out_q.byte_index;
  assign frame_flags_o     = out_q.frame_flags;
  assign fragment_offset_o = out_q.fragment_offset;
  assign payload_size_o    = out_q.payload_size;
  assign verdict_o         = out_q.verdict;
  assign frame_last_o      = out_q.frame_last;

endmodule

### tb/tb_wire_frame_receiver_crc32_top.sv
// ----------------------------------------------------------------------------
// tb_wire_frame_receiver_crc32_top
// Feeds byte streams of frames into the receiver: a table of directed frames
// for each verdict and field extreme, then random frames across three register
// settings with random idling on both channels and a long output hold-off.
// Every result is checked against a frame parser and CRC-32 model kept here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_wire_frame_receiver_crc32_top;
  import wfr_pkg::*;

  localparam int          MAX_PAY         = MAX_PAYLOAD_DEF;
  localparam logic [31:0] FRAME_MAGIC     = 32'h3335_324A;
  localparam logic [2:0]  NO_VERDICT      = 3'd7;
  localparam int          ITEMS_PER_PHASE = 250;
  localparam int          HOLD_CYCLES     = 300;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          CYCLE_LIMIT     = 400000;
  localparam int          MAX_REPORTS     = 10;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [7:0]  index;
    logic [15:0] flags;
    logic [15:0] offset;
    logic [7:0]  size;
    logic [2:0]  verdict;
    logic        last;
  } rx_item_t;

  typedef struct packed {
    logic [31:0] magic;
    logic [7:0]  version;
    logic [7:0]  op;
    logic [15:0] flags;
    logic [31:0] seq;
    logic [15:0] offset;
    logic [15:0] size;
    logic [31:0] crc_xor;
    logic [2:0]  verdict;
  } frame_row_t;

  localparam int DIRECTED_COUNT = 17;
  localparam frame_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{FRAME_MAGIC, VERSION_OK, 8'h00, 16'h0000, 32'h0, 16'h0000, 16'd0, 32'h0, VERDICT_OK},
    '{FRAME_MAGIC, VERSION_OK, 8'h00, 16'hFFFF, 32'h0, 16'hFFFF, 16'd192, 32'h0, VERDICT_OK},
    '{FRAME_MAGIC, VERSION_OK, 8'h00, 16'h8001, 32'h0, 16'h1234, 16'd1, 32'h0, VERDICT_OK},
    '{FRAME_MAGIC ^ 32'h0000_00FF, VERSION_OK, 8'h00, 16'h0, 32'h0, 16'h0, 16'd4, 32'h0,
      VERDICT_MAGIC},
    '{FRAME_MAGIC ^ 32'h8000_0000, VERSION_OK, 8'h00, 16'h0, 32'h0, 16'h0, 16'd4, 32'h0,
      VERDICT_MAGIC},
    '{FRAME_MAGIC ^ 32'h0000_0100, 8'h00, 8'h00, 16'h0, 32'h0, 16'h0, 16'd4, 32'h0,
      VERDICT_MAGIC},
    '{FRAME_MAGIC, 8'h00, 8'h00, 16'h0, 32'h0, 16'h0, 16'd2, 32'h0, VERDICT_VERSION},
    '{FRAME_MAGIC, 8'hFF, 8'hFF, 16'h0, 32'h0, 16'h0, 16'd2, 32'h0, VERDICT_VERSION},
    '{FRAME_MAGIC, VERSION_OK, 8'hFF, 16'h0, 32'h0, 16'h0, 16'd2, 32'h0, VERDICT_OP},
    '{FRAME_MAGIC, VERSION_OK, 8'h80, 16'h0, 32'hFFFF_FFFF, 16'h0, 16'd193, 32'h0,
      VERDICT_OP},
    '{FRAME_MAGIC, VERSION_OK, 8'h00, 16'h0, 32'hFFFF_FFFF, 16'h0, 16'd0, 32'h0,
      VERDICT_SEQUENCE},
    '{FRAME_MAGIC, VERSION_OK, 8'h00, 16'h0, 32'h0000_0001, 16'h0, 16'd500, 32'h0,
      VERDICT_SEQUENCE},
    '{FRAME_MAGIC, VERSION_OK, 8'h00, 16'h0, 32'h0, 16'h0, 16'd193, 32'h0, VERDICT_OVERSIZE},
    '{FRAME_MAGIC, VERSION_OK, 8'h00, 16'h0, 32'h0, 16'h0, 16'hFFFF, 32'h0, VERDICT_OVERSIZE},
    '{FRAME_MAGIC, VERSION_OK, 8'h00, 16'h0, 32'h0, 16'h0, 16'h0100, 32'h0, VERDICT_OVERSIZE},
    '{FRAME_MAGIC, VERSION_OK, 8'h00, 16'h0, 32'h0, 16'h0, 16'd3, 32'h0000_0001, VERDICT_CRC},
    '{FRAME_MAGIC, VERSION_OK, 8'h00, 16'h0, 32'h0, 16'h0, 16'd0, 32'h8000_0000, VERDICT_CRC}
  };

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [7:0]           rx_byte_i   = 8'h00;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 item_kind_o;
  logic [7:0]           payload_byte_o;
  logic [7:0]           byte_index_o;
  logic [15:0]          frame_flags_o;
  logic [15:0]          fragment_offset_o;
  logic [7:0]           payload_size_o;
  logic [2:0]           verdict_o;
  logic                 frame_last_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0]          cfg_data_i  = '0;

  // parser state and register copies
  int unsigned frame_pos;
  logic [31:0] crc_run;
  logic [31:0] crc_seen;
  logic [15:0] hdr_flags;
  logic [15:0] hdr_offset;
  logic [15:0] hdr_size;
  logic [31:0] hdr_seq;
  logic [2:0]  hdr_fault;
  logic [7:0]  want_op;
  logic [31:0] want_seq;

  rx_item_t    frame_items_due[$];
  logic [7:0]  frame_bytes[$];
  logic [2:0]  last_verdict;
  int          verdict_count[8];
  int          payload_count;
  int          bytes_sent;
  int          results_seen;
  int          fail_count;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          phase_no;
  int          hold_count;

  wire_frame_receiver_crc32_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .item_kind_o       (item_kind_o),
    .payload_byte_o    (payload_byte_o),
    .byte_index_o      (byte_index_o),
    .frame_flags_o     (frame_flags_o),
    .fragment_offset_o (fragment_offset_o),
    .payload_size_o    (payload_size_o),
    .verdict_o         (verdict_o),
    .frame_last_o      (frame_last_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic string item_text(input rx_item_t it);
    return $sformatf({"kind %0d byte %02h index %0d flags %04h offset %04h",
                      " size %0d verdict %0d last %0d"},
                     it.kind, it.data, it.index, it.flags, it.offset, it.size, it.verdict, it.last);
  endfunction

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("mismatch: %s", msg);
    end
  endtask

  task automatic flag_fault(input logic [2:0] code);
    if (hdr_fault == VERDICT_OK) begin
      hdr_fault = code;
    end
  endtask

  task automatic restart_frame();
    frame_pos = 0;
    crc_run   = CRC_INIT;
    hdr_fault = VERDICT_OK;
    crc_seen  = '0;
  endtask

  task automatic queue_status(input logic [2:0] code);
    rx_item_t it;
    it         = '0;
    it.kind    = ITEM_STATUS;
    it.flags   = hdr_flags;
    it.offset  = hdr_offset;
    it.size    = (hdr_size > 16'd255) ? 8'hFF : hdr_size[7:0];
    it.verdict = code;
    it.last    = 1'b1;
    frame_items_due.push_back(it);
    verdict_count[code]++;
    last_verdict = code;
    restart_frame();
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    rx_item_t    it;
    int unsigned k;
    if (frame_pos < HDR_BYTES) begin
      if (frame_pos >= 4) begin
        crc_run = crc32_update(crc_run, b);
      end
      case (frame_pos)
        0, 1, 2, 3: if (b != FRAME_MAGIC[8*frame_pos +: 8]) flag_fault(VERDICT_MAGIC);
        4: if (b != VERSION_OK) flag_fault(VERDICT_VERSION);
        5: if (b != want_op) flag_fault(VERDICT_OP);
        6: hdr_flags[7:0] = b;
        7: hdr_flags[15:8] = b;
        8, 9, 10: hdr_seq[8*(frame_pos-8) +: 8] = b;
        11: begin
          hdr_seq[31:24] = b;
          if (hdr_seq != want_seq) flag_fault(VERDICT_SEQUENCE);
        end
        12: hdr_offset[7:0] = b;
        13: hdr_offset[15:8] = b;
        14: hdr_size[7:0] = b;
        default: begin
          hdr_size[15:8] = b;
          if (hdr_size > MAX_PAY) flag_fault(VERDICT_OVERSIZE);
        end
      endcase
      if (frame_pos == HDR_BYTES - 1 && hdr_fault != VERDICT_OK) begin
        queue_status(hdr_fault);
      end else begin
        frame_pos++;
      end
    end else if (frame_pos < HDR_BYTES + hdr_size) begin
      crc_run  = crc32_update(crc_run, b);
      it       = '0;
      it.kind  = ITEM_PAYLOAD;
      it.data  = b;
      it.index = (frame_pos - HDR_BYTES > 255) ? 8'hFF : 8'(frame_pos - HDR_BYTES);
      frame_items_due.push_back(it);
      payload_count++;
      frame_pos++;
    end else begin
      k = (frame_pos - HDR_BYTES - hdr_size) % 4;
      crc_seen[8*k +: 8] = b;
      if (k == 3) begin
        queue_status((crc_seen == ~crc_run) ? VERDICT_OK : VERDICT_CRC);
      end else begin
        frame_pos++;
      end
    end
  endtask

  task automatic build_frame(input logic [31:0] magic, input logic [7:0] version,
                             input logic [7:0] op, input logic [15:0] flags,
                             input logic [31:0] seq, input logic [15:0] offset,
                             input logic [15:0] size, input logic [31:0] crc_xor,
                             input bit header_only);
    logic [127:0] hdr;
    logic [31:0]  crc;
    logic [7:0]   b;
    frame_bytes.delete();
    hdr = {size, offset, seq, flags, op, version, magic};
    crc = CRC_INIT;
    for (int i = 0; i < HDR_BYTES; i++) begin
      frame_bytes.push_back(hdr[8*i +: 8]);
      if (i >= 4) crc = crc32_update(crc, hdr[8*i +: 8]);
    end
    if (!header_only) begin
      for (int i = 0; i < size; i++) begin
        b = 8'($urandom());
        frame_bytes.push_back(b);
        crc = crc32_update(crc, b);
      end
      crc = ~crc ^ crc_xor;
      for (int i = 0; i < 4; i++) begin
        frame_bytes.push_back(crc[8*i +: 8]);
      end
    end
  endtask

  task automatic push_rx_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    parse_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame_bytes();
    foreach (frame_bytes[i]) begin
      push_rx_byte(frame_bytes[i]);
    end
  endtask

  task automatic send_random_frame();
    logic [31:0] magic;
    logic [31:0] seq;
    logic [31:0] crc_xor;
    logic [7:0]  version;
    logic [7:0]  op;
    logic [15:0] size;
    int unsigned pick;
    int unsigned idx;
    bit          header_only;
    pick        = $urandom_range(99);
    magic       = FRAME_MAGIC;
    version     = VERSION_OK;
    op          = want_op;
    seq         = want_seq;
    crc_xor     = '0;
    header_only = 1'b0;
    size = ($urandom_range(19) == 0) ? 16'($urandom_range(MAX_PAY)) : 16'($urandom_range(12));
    if (pick < 10) begin
      // garbage header: one whole header length of noise keeps alignment
      frame_bytes.delete();
      repeat (HDR_BYTES) frame_bytes.push_back(8'($urandom()));
    end else begin
      if (pick < 34) begin
        header_only = 1'b1;
        case ($urandom_range(5))
          0: begin
            idx = $urandom_range(3);
            magic[8*idx +: 8] ^= 8'($urandom_range(1, 255));
          end
          1: version ^= 8'($urandom_range(1, 255));
          2: op ^= 8'($urandom_range(1, 255));
          3: seq ^= $urandom() | (32'h1 << $urandom_range(31));
          4: size = $urandom_range(1) ? 16'(MAX_PAY + 1)
                                      : 16'($urandom_range(MAX_PAY + 1, 65535));
          default: begin
            header_only = 1'b0;
            crc_xor = $urandom() | (32'h1 << $urandom_range(31));
          end
        endcase
      end
      build_frame(magic, version, op, 16'($urandom()), seq, 16'($urandom()), size, crc_xor,
                  header_only);
    end
    send_frame_bytes();
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (index == CFG_EXPECTED_OP) begin
      want_op = value[7:0];
    end else begin
      want_seq = value;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    recv_idle_pct = 0;
    while (frame_items_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (phase_no == 3 && hold_count < HOLD_CYCLES) begin
      out_stall_i <= 1'b1;
      hold_count++;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    rx_item_t seen;
    rx_item_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = '{item_kind_o, payload_byte_o, byte_index_o, frame_flags_o, fragment_offset_o,
               payload_size_o, verdict_o, frame_last_o};
      if (frame_items_due.size() == 0) begin
        log_failure($sformatf("result %0d not expected: %s", results_seen, item_text(seen)));
      end else begin
        due = frame_items_due.pop_front();
        if (seen !== due) begin
          log_failure($sformatf("result %0d\n  expected %s\n  actual   %s",
                                results_seen, item_text(due), item_text(seen)));
        end
      end
      results_seen++;
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[wire_frame_receiver_crc32_top] ERROR");
    $finish;
  end

  initial begin : stimulus
    frame_row_t row;
    bit         header_only;
    int         phase_start;
    int         header_faults;
    hdr_flags     = '0;
    hdr_offset    = '0;
    hdr_size      = '0;
    hdr_seq       = '0;
    want_op       = '0;
    want_seq      = '0;
    payload_count = 0;
    bytes_sent    = 0;
    results_seen  = 0;
    fail_count    = 0;
    phase_no      = 0;
    hold_count    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (verdict_count[i]) verdict_count[i] = 0;
    restart_frame();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_register(CFG_EXPECTED_OP, 32'h0);
    write_register(CFG_EXPECTED_SEQ, 32'h0);
    send_idle_pct = 31;
    recv_idle_pct = 85;
    for (int r = 0; r < DIRECTED_COUNT; r++) begin
      row          = DIRECTED_ROWS[r];
      header_only  = (row.verdict != VERDICT_OK) && (row.verdict != VERDICT_CRC);
      last_verdict = NO_VERDICT;
      build_frame(row.magic, row.version, row.op, row.flags, row.seq, row.offset, row.size,
                  row.crc_xor, header_only);
      send_frame_bytes();
      if (last_verdict != row.verdict) begin
        log_failure($sformatf("directed frame %0d: verdict %0d, table gives %0d",
                              r, last_verdict, row.verdict));
      end
    end

    for (int ph = 1; ph <= 3; ph++) begin
      settle_block();
      if (ph == 1) begin
        write_register(CFG_EXPECTED_OP, {24'($urandom()), 8'hFF});
        write_register(CFG_EXPECTED_SEQ, 32'hFFFF_FFFF);
      end else begin
        write_register(CFG_EXPECTED_OP, $urandom());
        write_register(CFG_EXPECTED_SEQ, $urandom());
      end
      case (ph)
        1: begin
          send_idle_pct = 31;
          recv_idle_pct = 85;
        end
        2: begin
          send_idle_pct = 85;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_no    = ph;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < ITEMS_PER_PHASE) send_random_frame();
    end
    settle_block();

    header_faults = 0;
    for (int v = VERDICT_MAGIC; v <= VERDICT_OVERSIZE; v++) header_faults += verdict_count[v];
    $display("covered %0d frames: %0d ok, %0d header faults, %0d crc faults; %0d payload bytes",
             verdict_count[VERDICT_OK] + header_faults + verdict_count[VERDICT_CRC],
             verdict_count[VERDICT_OK], header_faults, verdict_count[VERDICT_CRC], payload_count);
    $display("%0d bytes sent, %0d results checked in %0d cycles over four register settings",
             bytes_sent, results_seen, cycle_count);
    if (fail_count == 0) begin
      $display("[wire_frame_receiver_crc32_top] OK");
    end else begin
      $display("[wire_frame_receiver_crc32_top] ERROR");
    end
    $finish;
  end

endmodule
